// File: rtl/shabs_pkg.sv
// Shared types, constants and command structs of the SHA-256 byte-stream hasher.
package shabs_pkg;

    typedef logic [31:0] word_t;

    // Eight hash words packed with h0 in the top slot
    typedef logic [7:0][31:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] LEN_LAST   = 3'd7;
    localparam logic [1:0] PART_LAST  = 2'd3;

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARKER,
        SRC_ZERO,
        SRC_LENGTH
    } byte_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       push;
        byte_src_t  src;
        logic [2:0] len_idx;
        logic       count_byte;
        logic       init_work;
        logic       do_round;
        logic [5:0] round_idx;
        logic       finalize;
        logic       load_part;
        logic [1:0] part_idx;
        logic       restart;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/shabs_in_if.sv
// Input channel: at most one message byte per item with valid/ready handshake.
interface shabs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output has_byte, output is_last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

// File: rtl/shabs_out_if.sv
// Output channel: one 64-bit digest quarter per item with valid/ready handshake.
interface shabs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        is_final_part;

    modport source (output valid, output digest_part, output part_index,
                    output is_final_part, input ready);
    modport sink (input valid, input digest_part, input part_index,
                  input is_final_part, output ready);
endinterface

// File: rtl/sha256_byte_stream_hash.sv
// Top level of the SHA-256 byte-stream hasher: controller plus datapath.
//
// Usage: each item on msg carries one message byte (has_byte = 1) or none,
// and is_last = 1 closes the message. The block then pads, compresses and
// returns the 256-bit digest on the digest channel as four items, part_index
// 0 to 3, with h0/h1 in part 0 and is_final_part set on part 3. It then
// starts over from the initial hash value for the next message.
// Throughput: one byte per cycle while the 64-byte block buffer fills. The
// 64th byte of a block starts compression: 64 rounds in a single shared
// round unit, then a step that adds into the hash words, all with msg.ready
// low. Closing a message shifts in the padding bytes one at a time (marker,
// zeros, eight length bytes) with a pause before the length bytes, runs one
// or two compressions, then hands out the four digest items.
// The digest leaves through an output register; a stalled receiver holds the
// current digest item and pauses the remaining ones, and the next message is
// accepted as soon as the last item sits in that register.
// Reset returns to the initial hash value with an empty message; there is no
// clearing pass.
module sha256_byte_stream_hash (
    input  logic      clk,
    input  logic      rst_n,
    shabs_in_if.sink  msg,
    shabs_out_if.source digest
);

    shabs_pkg::dp_cmd_t    cmd;
    shabs_pkg::dp_status_t status;

    shabs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .has_byte (msg.has_byte),
        .is_last  (msg.is_last),
        .in_ready (msg.ready),
        .status   (status),
        .cmd      (cmd)
    );

    shabs_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (msg.data_byte),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (digest.valid),
        .out_ready     (digest.ready),
        .digest_part   (digest.digest_part),
        .part_index    (digest.part_index),
        .is_final_part (digest.is_final_part)
    );

endmodule

// File: rtl/shabs_ctrl.sv
// Controller: sequences byte intake, padding, compression rounds and digest output.
module shabs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  has_byte,
    input  logic                  is_last,
    output logic                  in_ready,
    input  shabs_pkg::dp_status_t status,
    output shabs_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_ACCEPT = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_FINAL  = 5'b00100,
        ST_PAD    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        PAD_MARK = 4'b0001,
        PAD_ZERO = 4'b0010,
        PAD_LEN  = 4'b0100,
        PAD_DONE = 4'b1000
    } pad_t;

    state_t     state_reg, state_next;
    pad_t       pad_reg, pad_next;
    logic       padding_reg, padding_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] len_reg, len_next;
    logic [1:0] part_reg, part_next;
    logic       push;

    // Next-state and command decode
    always_comb
    begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        padding_next = padding_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        len_next     = len_reg;
        part_next    = part_reg;
        push         = 1'b0;
        cmd          = '0;
        cmd.src      = shabs_pkg::SRC_INPUT;
        cmd.len_idx  = len_reg;
        cmd.round_idx = round_reg;
        cmd.part_idx = part_reg;
        in_ready     = (state_reg == ST_ACCEPT);

        case (state_reg)
            ST_ACCEPT:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        push           = 1'b1;
                        cmd.count_byte = 1'b1;
                    end
                    if (is_last)
                    begin
                        padding_next = 1'b1;
                        pad_next     = PAD_MARK;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == shabs_pkg::ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.finalize = 1'b1;
                if (!padding_reg)
                begin
                    state_next = ST_ACCEPT;
                end
                else if (pad_reg == PAD_DONE)
                begin
                    part_next  = 2'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                case (pad_reg)
                    PAD_MARK:
                    begin
                        push     = 1'b1;
                        cmd.src  = shabs_pkg::SRC_MARKER;
                        pad_next = PAD_ZERO;
                    end
                    PAD_ZERO:
                    begin
                        if (fill_reg == shabs_pkg::LEN_START)
                        begin
                            pad_next = PAD_LEN;
                            len_next = 3'd0;
                        end
                        else
                        begin
                            push    = 1'b1;
                            cmd.src = shabs_pkg::SRC_ZERO;
                        end
                    end
                    PAD_LEN:
                    begin
                        push     = 1'b1;
                        cmd.src  = shabs_pkg::SRC_LENGTH;
                        len_next = len_reg + 3'd1;
                        if (len_reg == shabs_pkg::LEN_LAST)
                        begin
                            pad_next = PAD_DONE;
                        end
                    end
                    default:
                    begin
                        part_next  = 2'd0;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_part = 1'b1;
                    part_next     = part_reg + 2'd1;
                    if (part_reg == shabs_pkg::PART_LAST)
                    begin
                        cmd.restart  = 1'b1;
                        padding_next = 1'b0;
                        fill_next    = 6'd0;
                        state_next   = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase

        // Advance the fill count; a full block starts compression
        cmd.push = push;
        if (push)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == shabs_pkg::BLOCK_LAST)
            begin
                fill_next     = 6'd0;
                cmd.init_work = 1'b1;
                round_next    = 6'd0;
                state_next    = ST_ROUND;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCEPT;
            pad_reg     <= PAD_MARK;
            padding_reg <= 1'b0;
            fill_reg    <= 6'd0;
            round_reg   <= 6'd0;
            len_reg     <= 3'd0;
            part_reg    <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            padding_reg <= padding_next;
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            len_reg     <= len_next;
            part_reg    <= part_next;
        end
    end

endmodule

// File: rtl/shabs_datapath.sv
// Datapath: block buffer and message schedule, round unit, hash words, output register.
module shabs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            data_byte,
    input  shabs_pkg::dp_cmd_t    cmd,
    output shabs_pkg::dp_status_t status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           digest_part,
    output logic [1:0]            part_index,
    output logic                  is_final_part
);

    function automatic shabs_pkg::word_t rotr(input shabs_pkg::word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Block buffer; during rounds it doubles as the 16-word schedule window
    logic [511:0]       buf_reg;
    shabs_pkg::hash_t   hash_reg;
    shabs_pkg::word_t   work_reg [8];
    logic [60:0]        count_reg;
    logic               out_valid_reg;
    logic [63:0]        digest_reg;
    logic [1:0]         part_reg;
    logic               final_reg;

    logic [63:0]        len_bits;
    logic [7:0]         byte_in;
    shabs_pkg::word_t   w_now, w_new, sg0, sg1;
    shabs_pkg::word_t   big0, big1, choose, major, t1, t2;
    logic [3:0][63:0]   hash_parts;

    assign len_bits   = {count_reg, 3'b000};
    assign hash_parts = hash_reg;

    // Select the byte to shift in
    always_comb
    begin
        case (cmd.src)
            shabs_pkg::SRC_INPUT:  byte_in = data_byte;
            shabs_pkg::SRC_MARKER: byte_in = shabs_pkg::PAD_MARKER;
            shabs_pkg::SRC_ZERO:   byte_in = 8'd0;
            shabs_pkg::SRC_LENGTH: byte_in = len_bits[{~cmd.len_idx, 3'b000} +: 8];
            default:               byte_in = 8'd0;
        endcase
    end

    // Message schedule: next word from the window
    assign w_now = buf_reg[511:480];
    assign sg0   = rotr(buf_reg[479:448], 7) ^ rotr(buf_reg[479:448], 18)
                   ^ (buf_reg[479:448] >> 3);
    assign sg1   = rotr(buf_reg[63:32], 17) ^ rotr(buf_reg[63:32], 19)
                   ^ (buf_reg[63:32] >> 10);
    assign w_new = w_now + sg0 + buf_reg[223:192] + sg1;

    // One compression round
    assign big1   = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
    assign choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign t1     = work_reg[7] + big1 + choose + shabs_pkg::ROUND_K[cmd.round_idx] + w_now;
    assign big0   = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
    assign major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                    ^ (work_reg[1] & work_reg[2]);
    assign t2     = big0 + major;

    // Shift bytes in, or advance the schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            buf_reg <= {buf_reg[503:0], byte_in};
        end
        else if (cmd.do_round)
        begin
            buf_reg <= {buf_reg[479:0], w_new};
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (cmd.init_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[7 - i];
            end
        end
        else if (cmd.do_round)
        begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    // Hash words and message byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= shabs_pkg::INIT_HASH;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                hash_reg  <= shabs_pkg::INIT_HASH;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.finalize)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[7 - i] <= hash_reg[7 - i] + work_reg[i];
                    end
                end
                if (cmd.count_byte)
                begin
                    count_reg <= count_reg + 61'd1;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_part)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_part)
        begin
            digest_reg <= hash_parts[~cmd.part_idx];
            part_reg   <= cmd.part_idx;
            final_reg  <= (cmd.part_idx == shabs_pkg::PART_LAST);
        end
    end

    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign digest_part     = digest_reg;
    assign part_index      = part_reg;
    assign is_final_part   = final_reg;

endmodule
